// ----- hdl/ubxp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubxp_pkg
// Shared types and constants for the UBX frame parser.
// ----------------------------------------------------------------------------
package ubxp_pkg;

  localparam int MAX_PAYLOAD_DEF = 512;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;
  localparam logic [7:0] ACK_CLASS   = 8'h05;
  localparam logic [7:0] ACK_ID      = 8'h01;
  localparam logic [7:0] NAK_ID      = 8'h00;

  localparam logic [2:0] ST_UNUSED     = 3'd0;
  localparam logic [2:0] ST_INCOMPLETE = 3'd1;
  localparam logic [2:0] ST_COMPLETE   = 3'd2;
  localparam logic [2:0] ST_ACK        = 3'd3;
  localparam logic [2:0] ST_NAK        = 3'd4;

  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN_LO  = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CHK_A   = 4'd7,
    PH_CHK_B   = 4'd8
  } phase_t;

  // Control for the running checksum
  typedef struct packed {
    logic       en;     // fold data into the sum this cycle
    logic       clear;  // restart the sum with data as first byte
    logic [7:0] data;
  } sum_ctrl_t;

endpackage

// ----- hdl/ubxp_fletcher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubxp_fletcher
// Running 8-bit Fletcher sum (A and B) over the frame bytes.
// ----------------------------------------------------------------------------
module ubxp_fletcher (
  input  logic                clk,
  input  logic                rst,
  input  ubxp_pkg::sum_ctrl_t ctrl,
  output logic [7:0]          sum_a,
  output logic [7:0]          sum_b
);
  import ubxp_pkg::*;

  logic [7:0] sum_a_next;
  logic [7:0] sum_b_next;

  always_comb begin
    sum_a_next = ctrl.clear ? ctrl.data : 8'(sum_a + ctrl.data);
    sum_b_next = ctrl.clear ? ctrl.data : 8'(sum_b + sum_a_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_a <= '0;
      sum_b <= '0;
    end else if (ctrl.en) begin
      sum_a <= sum_a_next;
      sum_b <= sum_b_next;
    end
  end

endmodule

// ----- hdl/ubx_frame_parser.sv -----
`timescale 1ns / 1ps
// An accepted input beat passes through the input register and then the result register.
// Throughput: one byte per cycle while res_stall is low; the parse step is a single
// pass between the input register and the result register.
// Reset (synchronous, active high) empties both registers, returns the parser
// to sync hunting and clears the running sum, frame fields and all counters.
// ----------------------------------------------------------------------------
// ubx_frame_parser
// UBX byte-stream parser: sync hunt, header capture, payload pass-through,
// Fletcher-8 check, frame status and wrapping error/receive counters.
// ----------------------------------------------------------------------------
module ubx_frame_parser #(
  parameter int MAX_PAYLOAD = ubxp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  status,
  output logic        payload_valid,
  output logic [7:0]  payload_byte,
  output logic [8:0]  payload_index,
  output logic [7:0]  msg_class,
  output logic [7:0]  msg_id,
  output logic [9:0]  msg_length,
  output logic [31:0] overflow_count,
  output logic [31:0] checksum_error_count,
  output logic [31:0] received_count
);
  import ubxp_pkg::*;

  localparam int BT_W = $clog2(MAX_PAYLOAD + 1);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       adv;

  // parser state
  phase_t          phase, phase_next;
  logic [7:0]      frame_class, frame_class_next;
  logic [7:0]      frame_id, frame_id_next;
  logic [15:0]     frame_length, frame_length_next;
  logic [BT_W-1:0] bytes_taken, bytes_taken_next;
  logic [BT_W-1:0] bt_inc;
  logic [7:0]      got_check_a, got_check_a_next;
  logic [31:0]     overflow_tally, overflow_tally_next;
  logic [31:0]     checksum_tally, checksum_tally_next;
  logic [31:0]     received_tally, received_tally_next;

  logic [7:0]  sum_a, sum_b;
  sum_ctrl_t   sum_ctrl;

  // step results
  logic [2:0]  st_c;
  logic        pv_c;
  logic [7:0]  pbyte_c;
  logic [8:0]  pidx_c;

  assign adv      = s1_valid && (!res_valid || !res_stall);
  assign rx_stall = s1_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || adv) begin
      s1_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && !rx_stall) begin
      s1_byte <= rx_byte;
    end
  end

  ubxp_fletcher u_fletcher (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (sum_ctrl),
    .sum_a (sum_a),
    .sum_b (sum_b)
  );

  assign bt_inc = bytes_taken + 1'b1;

  always_comb begin
    phase_next          = phase;
    frame_class_next    = frame_class;
    frame_id_next       = frame_id;
    frame_length_next   = frame_length;
    bytes_taken_next    = bytes_taken;
    got_check_a_next    = got_check_a;
    overflow_tally_next = overflow_tally;
    checksum_tally_next = checksum_tally;
    received_tally_next = received_tally;
    st_c                = ST_INCOMPLETE;
    pv_c                = 1'b0;
    pbyte_c             = '0;
    pidx_c              = '0;
    sum_ctrl.en         = 1'b0;
    sum_ctrl.clear      = 1'b0;
    sum_ctrl.data       = s1_byte;

    unique case (phase)
      PH_SYNC2: begin
        if (s1_byte == SYNC_SECOND) begin
          phase_next = PH_CLASS;
        end else begin
          phase_next = PH_SYNC1;
          st_c       = ST_UNUSED;
        end
      end
      PH_CLASS: begin
        frame_class_next = s1_byte;
        sum_ctrl.en      = adv;
        sum_ctrl.clear   = 1'b1;
        phase_next       = PH_ID;
      end
      PH_ID: begin
        frame_id_next = s1_byte;
        sum_ctrl.en   = adv;
        phase_next    = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        frame_length_next = {8'h00, s1_byte};
        sum_ctrl.en       = adv;
        phase_next        = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        frame_length_next = {s1_byte, frame_length[7:0]};
        sum_ctrl.en       = adv;
        if ({1'b0, frame_length_next} > 17'(MAX_PAYLOAD)) begin
          overflow_tally_next = overflow_tally + 32'd1;
          phase_next          = PH_SYNC1;
          st_c                = ST_UNUSED;
        end else begin
          bytes_taken_next = '0;
          phase_next       = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (16'(bytes_taken) < frame_length) begin
          pv_c             = 1'b1;
          pbyte_c          = s1_byte;
          pidx_c           = 9'(bytes_taken);
          sum_ctrl.en      = adv;
          bytes_taken_next = bt_inc;
          if (16'(bt_inc) == frame_length) begin
            phase_next = PH_CHK_A;
          end
        end else begin
          // zero-length frame lands here
          overflow_tally_next = overflow_tally + 32'd1;
          phase_next          = PH_SYNC1;
          st_c                = ST_UNUSED;
        end
      end
      PH_CHK_A: begin
        got_check_a_next = s1_byte;
        phase_next       = PH_CHK_B;
      end
      PH_CHK_B: begin
        phase_next = PH_SYNC1;
        if (got_check_a == sum_a && s1_byte == sum_b) begin
          received_tally_next = received_tally + 32'd1;
          if (frame_class == ACK_CLASS && frame_id == ACK_ID) begin
            st_c = ST_ACK;
          end else if (frame_class == ACK_CLASS && frame_id == NAK_ID) begin
            st_c = ST_NAK;
          end else begin
            st_c = ST_COMPLETE;
          end
        end else begin
          checksum_tally_next = checksum_tally + 32'd1;
          st_c                = ST_UNUSED;
        end
      end
      default: begin
        if (s1_byte == SYNC_FIRST) begin
          phase_next = PH_SYNC2;
        end else begin
          phase_next = PH_SYNC1;
          st_c       = ST_UNUSED;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SYNC1;
      frame_class    <= '0;
      frame_id       <= '0;
      frame_length   <= '0;
      bytes_taken    <= '0;
      got_check_a    <= '0;
      overflow_tally <= '0;
      checksum_tally <= '0;
      received_tally <= '0;
    end else if (adv) begin
      phase          <= phase_next;
      frame_class    <= frame_class_next;
      frame_id       <= frame_id_next;
      frame_length   <= frame_length_next;
      bytes_taken    <= bytes_taken_next;
      got_check_a    <= got_check_a_next;
      overflow_tally <= overflow_tally_next;
      checksum_tally <= checksum_tally_next;
      received_tally <= received_tally_next;
    end
  end

  // result register; frame fields and counters are read from state, which
  // moves in lockstep with this register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      res_valid <= adv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status        <= st_c;
      payload_valid <= pv_c;
      payload_byte  <= pbyte_c;
      payload_index <= pidx_c;
    end
  end

  assign msg_class            = frame_class;
  assign msg_id               = frame_id;
  assign msg_length           = frame_length[9:0];
  assign overflow_count       = overflow_tally;
  assign checksum_error_count = checksum_tally;
  assign received_count       = received_tally;

  a_payload_incomplete: assert property (@(posedge clk) disable iff (rst)
    res_valid && payload_valid |-> status == ST_INCOMPLETE)
    else $error("payload beat with final status");

  a_payload_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> frame_length == 16'd0 || 16'(bytes_taken) < frame_length)
    else $error("payload index past frame length");

  a_recv_status: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && received_tally != $past(received_tally) |->
      res_valid && (status == ST_COMPLETE || status == ST_ACK || status == ST_NAK))
    else $error("receive count moved without a complete frame");

  a_chk_len: assert property (@(posedge clk) disable iff (rst)
    phase == PH_CHK_A |-> frame_length != 16'd0 && 16'(bytes_taken) == frame_length)
    else $error("checksum phase before payload done");

endmodule
